@@ design/satf_pkg.sv @@
// ----------------------------------------------------------------------------
// satf_pkg
// Shared types and constants of the sensor telemetry frame formatter.
// ----------------------------------------------------------------------------
package satf_pkg;

	localparam int unsigned FRAME_LEN  = 22;
	localparam int unsigned IDX_W      = 5;
	localparam logic [IDX_W-1:0] FRAME_LAST = IDX_W'(FRAME_LEN - 1);

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_OPEN    = 8'h28;
	localparam logic [7:0] CH_CLOSE   = 8'h29;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_MINUS   = 8'd45;
	localparam logic [7:0] CH_CR      = 8'h0D;

	localparam logic [7:0] TEMP_ZERO     = 8'd68;
	localparam logic [7:0] TEMP_POS_MUL  = 8'd150;
	localparam logic [7:0] TEMP_NEG_SPAN = 8'd55;
	localparam logic [7:0] POT_MUL       = 8'd100;

	// floor(x/d) == (x*M) >> S over the full operand range
	localparam logic [14:0] POT_RECIP   = 15'd20561;  // 1/51,  S = 20
	localparam logic [16:0] TPOS_RECIP  = 17'd89718;  // 1/187, S = 24
	localparam logic [13:0] TNEG_RECIP  = 14'd15421;  // 1/68,  S = 20

	typedef struct packed {
		logic [3:0] h;
		logic [3:0] t;
		logic [3:0] o;
	} dig3_t;

	typedef struct packed {
		dig3_t pot;
		dig3_t cnt;
		logic  tmp_neg;
		dig3_t tmp;
	} frame_rec_t;

endpackage

@@ design/satf_front.sv @@
// ----------------------------------------------------------------------------
// satf_front
// Three-stage front end: scales the readings and splits them into digits.
// ----------------------------------------------------------------------------
module satf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            pot_raw,
	input  logic [7:0]            count_raw,
	input  logic [7:0]            temp_raw,
	output logic                  rec_valid,
	input  logic                  rec_ready,
	output satf_pkg::frame_rec_t  rec
);

	function automatic satf_pkg::dig3_t bcd3(input logic [9:0] v);
		satf_pkg::dig3_t d;
		logic [9:0]      r;
		d.h = 4'd0;
		for (int i = 1; i <= 9; i++) begin
			if (v >= 10'(i * 100)) d.h = 4'(i);
		end
		r = v - (10'(d.h) * 10'd100);
		d.t = 4'd0;
		for (int i = 1; i <= 9; i++) begin
			if (r >= 10'(i * 10)) d.t = 4'(i);
		end
		r = r - (10'(d.t) * 10'd10);
		d.o = r[3:0];
		return d;
	endfunction

	logic        adv1, adv2, adv3;
	logic        v_s1, v_s2, v_s3;
	logic [14:0] pot_p_s1, tprod_s1;
	logic [7:0]  cnt_s1, cnt_s2;
	logic        tneg_s1, tneg_s2;
	logic [8:0]  hund_s2;
	logic [7:0]  tq_s2;
	satf_pkg::frame_rec_t rec_s3;

	logic        t_pos;
	logic [14:0] tprod_c;
	logic [29:0] hprod_c;
	logic [31:0] tpos_prod_c;
	logic [28:0] tneg_prod_c;
	logic [9:0]  tval_c;

	assign adv3     = !v_s3 || rec_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	assign t_pos   = temp_raw >= satf_pkg::TEMP_ZERO;
	assign tprod_c = t_pos ?
		15'(temp_raw - satf_pkg::TEMP_ZERO) * 15'(satf_pkg::TEMP_POS_MUL) :
		15'(temp_raw) * 15'(satf_pkg::TEMP_NEG_SPAN);

	assign hprod_c     = 30'(pot_p_s1) * 30'(satf_pkg::POT_RECIP);
	assign tpos_prod_c = 32'(tprod_s1) * 32'(satf_pkg::TPOS_RECIP);
	assign tneg_prod_c = 29'(tprod_s1) * 29'(satf_pkg::TNEG_RECIP);

	assign tval_c = tneg_s2 ? 10'(satf_pkg::TEMP_NEG_SPAN - tq_s2) : 10'(tq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			pot_p_s1 <= 15'(pot_raw) * 15'(satf_pkg::POT_MUL);
			cnt_s1   <= count_raw;
			tneg_s1  <= !t_pos;
			tprod_s1 <= tprod_c;
		end
		if (adv2 && v_s1) begin
			hund_s2 <= hprod_c[28:20];
			cnt_s2  <= cnt_s1;
			tneg_s2 <= tneg_s1;
			tq_s2   <= tneg_s1 ? {2'b00, tneg_prod_c[25:20]} : tpos_prod_c[31:24];
		end
		if (adv3 && v_s2) begin
			rec_s3.pot     <= bcd3(10'(hund_s2));
			rec_s3.cnt     <= bcd3(10'(cnt_s2));
			rec_s3.tmp_neg <= tneg_s2;
			rec_s3.tmp     <= bcd3(tval_c);
		end
	end

	assign rec_valid = v_s3;
	assign rec       = rec_s3;

endmodule

@@ design/satf_queue.sv @@
// ----------------------------------------------------------------------------
// satf_queue
// Small register queue of digit records between front and back.
// ----------------------------------------------------------------------------
module satf_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  satf_pkg::frame_rec_t  push_data,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output satf_pkg::frame_rec_t  pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	satf_pkg::frame_rec_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = count_q != CNT_FULL;
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ design/satf_back.sv @@
// ----------------------------------------------------------------------------
// satf_back
// Byte serializer: walks the 22 frame positions of the head record.
// ----------------------------------------------------------------------------
module satf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rec_valid,
	output logic                  rec_ready,
	input  satf_pkg::frame_rec_t  rec,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            tx_byte,
	output logic [4:0]            byte_index,
	output logic                  last_of_frame
);

	function automatic logic [7:0] asc(input logic [3:0] d);
		return satf_pkg::ASCII_ZERO + {4'b0000, d};
	endfunction

	logic [satf_pkg::IDX_W-1:0] idx_q;
	logic                       ov_q;
	logic [7:0]                 tx_q;
	logic [satf_pkg::IDX_W-1:0] bidx_q;
	logic                       last_q;
	logic                       load, at_last;
	logic [7:0]                 byte_c;

	assign load      = rec_valid && (!ov_q || out_ready);
	assign at_last   = idx_q == satf_pkg::FRAME_LAST;
	assign rec_ready = load && at_last;

	always_comb begin
		case (idx_q)
			5'd0, 5'd8, 5'd15:  byte_c = satf_pkg::CH_SPACE;
			5'd1, 5'd9, 5'd16:  byte_c = satf_pkg::CH_OPEN;
			5'd2:               byte_c = asc(rec.pot.h);
			5'd3:               byte_c = satf_pkg::CH_DOT;
			5'd4:               byte_c = asc(rec.pot.t);
			5'd5:               byte_c = asc(rec.pot.o);
			5'd6, 5'd13, 5'd20: byte_c = satf_pkg::CH_CLOSE;
			5'd7, 5'd14:        byte_c = satf_pkg::CH_COMMA;
			5'd10:              byte_c = asc(rec.cnt.h);
			5'd11:              byte_c = asc(rec.cnt.t);
			5'd12:              byte_c = asc(rec.cnt.o);
			5'd17:              byte_c = rec.tmp_neg ? satf_pkg::CH_MINUS : asc(rec.tmp.h);
			5'd18:              byte_c = asc(rec.tmp.t);
			5'd19:              byte_c = asc(rec.tmp.o);
			default:            byte_c = satf_pkg::CH_CR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (!ov_q || out_ready) ov_q <= rec_valid;
			if (load) idx_q <= at_last ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_q   <= byte_c;
			bidx_q <= idx_q;
			last_q <= at_last;
		end
	end

	assign out_valid     = ov_q;
	assign tx_byte       = tx_q;
	assign byte_index    = bidx_q;
	assign last_of_frame = last_q;

endmodule

@@ design/sensor_ascii_telemetry_frame_unit.sv @@
// ----------------------------------------------------------------------------
// sensor_ascii_telemetry_frame_unit
// Formats one set of sensor readings into a 22-byte ASCII telemetry frame.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat carries pot_raw, count_raw and
// temp_raw. Output channel (out_valid/out_ready): one beat per frame byte,
// with tx_byte, its byte_index 0..21 and last_of_frame on the closing CR.
// Path: byte 0 of a frame passes the three front stages, one queue slot and
// the output register before it is valid.
// Throughput: one output byte per cycle while out_ready is high; the
// serializer in the back end sets this. The front end takes a new reading
// set every cycle while its pipeline and the QUEUE_DEPTH-entry record queue
// have room, so input beats are taken while earlier frames still drain.
// Reset clears all valid flags and the byte position; the next frame starts
// at byte 0. When the receiver stalls, the output byte holds, the queue
// fills, and in_ready drops once the front pipeline is full as well.
// ----------------------------------------------------------------------------
module sensor_ascii_telemetry_frame_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] pot_raw,
	input  logic [7:0] count_raw,
	input  logic [7:0] temp_raw,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] tx_byte,
	output logic [4:0] byte_index,
	output logic       last_of_frame
);

	satf_pkg::frame_rec_t front_rec, back_rec;
	logic front_valid, front_ready, back_valid, back_ready;

	satf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pot_raw   (pot_raw),
		.count_raw (count_raw),
		.temp_raw  (temp_raw),
		.rec_valid (front_valid),
		.rec_ready (front_ready),
		.rec       (front_rec)
	);

	satf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_rec),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_rec)
	);

	satf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (back_valid),
		.rec_ready     (back_ready),
		.rec           (back_rec),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tx_byte       (tx_byte),
		.byte_index    (byte_index),
		.last_of_frame (last_of_frame)
	);

endmodule

@@ design/satf_checker.sv @@
// ----------------------------------------------------------------------------
// satf_checker
// Port-level checks of the telemetry frame formatter, bound to the top level.
// ----------------------------------------------------------------------------
module satf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] tx_byte,
	input logic [4:0] byte_index,
	input logic       last_of_frame
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_byte) &&
			$stable(byte_index) && $stable(last_of_frame))
		else $error("output beat changed while stalled");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_frame == (byte_index == 5'd21)))
		else $error("last_of_frame does not match byte position");

	a_next_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && byte_index != 5'd21 |=>
			out_valid && byte_index == $past(byte_index) + 5'd1)
		else $error("frame byte missing or out of order");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && byte_index == 5'd21 |=>
			!out_valid || byte_index == 5'd0)
		else $error("new frame does not start at byte 0");

endmodule

bind sensor_ascii_telemetry_frame_unit satf_checker u_satf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.tx_byte       (tx_byte),
	.byte_index    (byte_index),
	.last_of_frame (last_of_frame)
);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the sensor telemetry frame formatter.
// Drives reading sets through the input channel and checks every output beat
// (character, position, end-of-frame flag) against an in-bench formatter or
// typed frames. A directed table covers the reading extremes, the temperature
// sign change and mixed bit patterns, then random reading sets follow. Both
// channels idle and stall at random, with some stretches running at full rate.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned POT_DIV      = 51;
	localparam int unsigned TEMP_POS_DIV = 187;
	localparam int unsigned DIRECTED_N   = 16;
	localparam int unsigned RANDOM_N     = 414;
	localparam int unsigned DRAIN_CYCLES = 50;
	localparam int unsigned CYCLE_LIMIT  = 1500000;
	localparam int unsigned TXT_W        = satf_pkg::FRAME_LEN * 8;

	typedef struct packed {
		logic [7:0] ch;
		logic [4:0] pos;
		logic       eof;
	} frame_byte_t;

	typedef struct packed {
		logic [7:0]       pot;
		logic [7:0]       cnt;
		logic [7:0]       tmp;
		logic             typed;
		logic [TXT_W-1:0] txt;
	} reading_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] pot_raw;
	logic [7:0] count_raw;
	logic [7:0] temp_raw;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] tx_byte;
	logic [4:0] byte_index;
	logic       last_of_frame;

	frame_byte_t  pending_bytes[$];
	reading_row_t readings[$];
	int unsigned  mismatch_cnt = 0;
	int unsigned  cycle_cnt = 0;
	logic         calm = 1'b0;

	sensor_ascii_telemetry_frame_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pot_raw      (pot_raw),
		.count_raw    (count_raw),
		.temp_raw     (temp_raw),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.tx_byte      (tx_byte),
		.byte_index   (byte_index),
		.last_of_frame(last_of_frame)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [7:0] ascii_digit(input int unsigned v);
		return satf_pkg::ASCII_ZERO + 8'(v % 10);
	endfunction

	function automatic logic [TXT_W-1:0] render_frame(input logic [7:0] pot,
			input logic [7:0] cnt, input logic [7:0] tmp);
		int unsigned hv;
		int unsigned cv;
		int unsigned tv;
		logic [7:0]  t0, t1, t2;
		hv = (32'(pot) * satf_pkg::POT_MUL) / POT_DIV;
		cv = 32'(cnt);
		if (tmp >= satf_pkg::TEMP_ZERO) begin
			tv = ((32'(tmp) - satf_pkg::TEMP_ZERO) * satf_pkg::TEMP_POS_MUL) /
				TEMP_POS_DIV;
			t0 = ascii_digit(tv / 100);
		end else begin
			tv = satf_pkg::TEMP_NEG_SPAN -
				(32'(tmp) * satf_pkg::TEMP_NEG_SPAN) / satf_pkg::TEMP_ZERO;
			t0 = satf_pkg::CH_MINUS;
		end
		t1 = ascii_digit(tv / 10);
		t2 = ascii_digit(tv);
		return {satf_pkg::CH_SPACE, satf_pkg::CH_OPEN, ascii_digit(hv / 100),
			satf_pkg::CH_DOT, ascii_digit(hv / 10), ascii_digit(hv),
			satf_pkg::CH_CLOSE, satf_pkg::CH_COMMA,
			satf_pkg::CH_SPACE, satf_pkg::CH_OPEN, ascii_digit(cv / 100),
			ascii_digit(cv / 10), ascii_digit(cv), satf_pkg::CH_CLOSE,
			satf_pkg::CH_COMMA, satf_pkg::CH_SPACE, satf_pkg::CH_OPEN,
			t0, t1, t2, satf_pkg::CH_CLOSE, satf_pkg::CH_CR};
	endfunction

	task automatic queue_frame(input logic [TXT_W-1:0] txt);
		frame_byte_t fb;
		for (int unsigned k = 0; k < satf_pkg::FRAME_LEN; k++) begin
			fb.ch  = txt[(satf_pkg::FRAME_LEN - 1 - k) * 8 +: 8];
			fb.pos = 5'(k);
			fb.eof = (k == satf_pkg::FRAME_LEN - 1);
			pending_bytes.push_back(fb);
		end
	endtask

	task automatic add_row(input logic [7:0] p, input logic [7:0] c, input logic [7:0] t,
			input logic typed, input logic [TXT_W-1:0] txt);
		reading_row_t r;
		r.pot   = p;
		r.cnt   = c;
		r.tmp   = t;
		r.typed = typed;
		r.txt   = txt;
		readings.push_back(r);
	endtask

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// receiver: ready runs broken by random stalls
	initial begin
		int unsigned gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			gap = calm ? 0 : pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		frame_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bytes.size() == 0) begin
				flag_mismatch("unexpected beat", 32'(tx_byte), 0);
			end else begin
				want = pending_bytes.pop_front();
				if (tx_byte !== want.ch)
					flag_mismatch("tx_byte", 32'(tx_byte), 32'(want.ch));
				if (byte_index !== want.pos)
					flag_mismatch("byte_index", 32'(byte_index), 32'(want.pos));
				if (last_of_frame !== want.eof)
					flag_mismatch("last_of_frame", 32'(last_of_frame), 32'(want.eof));
			end
		end
	end

	initial begin
		reading_row_t row;
		int unsigned  gap;
		logic [7:0]   p, t;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		pot_raw   = '0;
		count_raw = '0;
		temp_raw  = '0;

		add_row(8'd0, 8'd0, 8'd0, 1'b1, {" (0.00), (000), (-55)", satf_pkg::CH_CR});
		add_row(8'd255, 8'd255, 8'd255, 1'b1, {" (5.00), (255), (150)", satf_pkg::CH_CR});
		add_row(8'd0, 8'd0, 8'd68, 1'b1, {" (0.00), (000), (000)", satf_pkg::CH_CR});
		add_row(8'd255, 8'd255, 8'd0, 1'b1, {" (5.00), (255), (-55)", satf_pkg::CH_CR});
		add_row(8'd51, 8'd100, 8'd67, 1'b0, '0);
		add_row(8'd1, 8'd99, 8'd69, 1'b0, '0);
		add_row(8'd254, 8'd9, 8'd254, 1'b0, '0);
		add_row(8'd128, 8'd10, 8'd1, 1'b0, '0);
		add_row(8'd50, 8'd1, 8'd187, 1'b0, '0);
		add_row(8'd102, 8'd199, 8'd34, 1'b0, '0);
		add_row(8'hAA, 8'h55, 8'hAA, 1'b0, '0);
		add_row(8'h55, 8'hAA, 8'h55, 1'b0, '0);
		add_row(8'd25, 8'd128, 8'd66, 1'b0, '0);
		add_row(8'd153, 8'd64, 8'd70, 1'b0, '0);
		add_row(8'd204, 8'd32, 8'd135, 1'b0, '0);
		add_row(8'd77, 8'd16, 8'd8, 1'b0, '0);
		for (int unsigned i = 0; i < RANDOM_N; i++) begin
			if ($urandom_range(0, 9) == 0)
				p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			else
				p = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 3) == 0)
				t = 8'($urandom_range(60, 76));
			else
				t = 8'($urandom_range(0, 255));
			add_row(p, 8'($urandom_range(0, 255)), t, 1'b0, '0);
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (readings[i]) begin
			row  = readings[i];
			calm = (i >= 120 && i < 180) || (i >= 320 && i < 360);
			gap  = calm ? 0 : pick_gap();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			in_valid  <= 1'b1;
			pot_raw   <= row.pot;
			count_raw <= row.cnt;
			temp_raw  <= row.tmp;
			do @(posedge clk); while (!in_ready);
			queue_frame(row.typed ? row.txt : render_frame(row.pot, row.cnt, row.tmp));
			@(negedge clk);
		end
		in_valid <= 1'b0;

		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
